### rtl/core/pinhole_point_projection_macros.svh
// assertion macros for the pinhole point projection block
// used by the port checker; expects clk and rst in scope
`ifndef PINHOLE_POINT_PROJECTION_MACROS_SVH
`define PINHOLE_POINT_PROJECTION_MACROS_SVH

// checked outside reset
`define PPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define PPP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ppp_pkg.sv
// shared types and constants of the pinhole point projection block
// no dependencies
`default_nettype none

package ppp_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int COEF_FRAC_BITS_DEF  = 14;
  localparam int FOCAL_FRAC          = 12;
  localparam int CTR_W               = 36;

  localparam logic [15:0] ROT_ONE = 16'd16384;
  localparam logic signed [38:0] CAM_LIMIT = 39'sh3F_FFFF_FFFF;

  localparam int DIV_NUM_W  = 74;
  localparam int DIV_DEN_W  = 38;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (DIV_NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int MAG_W      = DIV_NUM_W - FOCAL_FRAC;

  // accept to strobe, in cycles
  localparam int PIPE_LAT = DIV_STAGES + 6;

  typedef enum logic [2:0] {
    REG_ROT_ROW0    = 3'd0,
    REG_ROT_ROW1    = 3'd1,
    REG_ROT_ROW2    = 3'd2,
    REG_TRANS_XY    = 3'd3,
    REG_TRANS_Z     = 3'd4,
    REG_FOCAL       = 3'd5,
    REG_PRINCIPAL   = 3'd6,
    REG_IMAGE_CTL   = 3'd7
  } reg_idx_t;

  typedef enum logic {
    REQ_FWD = 1'b0,
    REQ_BWD = 1'b1
  } req_t;

  typedef struct packed {
    logic       valid;
    req_t       req;
    logic       inv;
    logic [1:0] neg;
    logic [1:0] nz;
  } ppp_ctl_t;

endpackage

`default_nettype wire

### rtl/core/ppp_div.sv
// pipelined restoring divider, two lanes, a few quotient bits per stage
// depends on ppp_pkg
`default_nettype none

module ppp_div #(
  parameter int NUM_W = ppp_pkg::DIV_NUM_W,
  parameter int DEN_W = ppp_pkg::DIV_DEN_W,
  parameter int STEPS = ppp_pkg::DIV_STEPS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ppp_pkg::ppp_ctl_t           in_ctl,
  input  logic [1:0][NUM_W-1:0]       in_num,
  input  logic [1:0][DEN_W-1:0]       in_den,
  output ppp_pkg::ppp_ctl_t           out_ctl,
  output logic [1:0][NUM_W-1:0]       out_quo
);

  localparam int NST = (NUM_W + STEPS - 1) / STEPS;

  ppp_pkg::ppp_ctl_t         ctl_q [NST];
  logic [1:0][DEN_W-1:0]     rem_q [NST];
  logic [1:0][DEN_W-1:0]     den_q [NST];
  logic [1:0][NUM_W-1:0]     num_q [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    ppp_pkg::ppp_ctl_t     ctl_i;
    logic [1:0][DEN_W-1:0] rem_i, den_i, rem_c;
    logic [1:0][NUM_W-1:0] num_i, num_c;
    logic [DEN_W:0]        trial, diff;

    if (s == 0) begin : g_first
      assign ctl_i = in_ctl;
      assign rem_i = '0;
      assign den_i = in_den;
      assign num_i = in_num;
    end else begin : g_next
      assign ctl_i = ctl_q[s-1];
      assign rem_i = rem_q[s-1];
      assign den_i = den_q[s-1];
      assign num_i = num_q[s-1];
    end

    always_comb begin
      rem_c = rem_i;
      num_c = num_i;
      trial = '0;
      diff  = '0;
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < STEPS; k++) begin
          if (s * STEPS + k < NUM_W) begin
            trial = {rem_c[l], num_c[l][NUM_W-1]};
            diff  = trial - {1'b0, den_i[l]};
            if (trial >= {1'b0, den_i[l]}) begin
              rem_c[l] = diff[DEN_W-1:0];
              num_c[l] = {num_c[l][NUM_W-2:0], 1'b1};
            end else begin
              rem_c[l] = trial[DEN_W-1:0];
              num_c[l] = {num_c[l][NUM_W-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s] <= rem_c;
      den_q[s] <= den_i;
      num_q[s] <= num_c;
    end
  end

  assign out_ctl = ctl_q[NST-1];
  assign out_quo = num_q[NST-1];

endmodule

`default_nettype wire

### rtl/core/pinhole_point_projection.sv
// top level of the pinhole point projection block
// depends on ppp_pkg and ppp_div
`default_nettype none

// Pinhole camera point unit.
// Requests: start with req_type and coord_x/y/z; a request is taken at an
// edge where start is high and busy is low. busy is low except in the cycle
// after a reset edge, so one request can be taken every cycle.
// req_type 0 maps a world point to a clamped pixel (depth_invalid on depth
// not positive), req_type 1 maps a pixel to a viewing ray.
// Results: done is high for one cycle with out_x/y/z and depth_invalid;
// the receiver cannot hold results off, and none is needed: results leave
// in request order, one per cycle at most.
// Pipeline: the 74-bit restoring divider at four quotient bits per stage
// (19 stages) plus six arithmetic stages, a to f; ppp_pkg::PIPE_LAT holds
// the latency from the accepting edge to the edge that takes the result.
// Throughput: one request per cycle while busy is low.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// at once; write only while no request is in flight.
// Reset: synchronous, clears the pipeline and loads the register defaults
// (identity rotation, everything else zero).

module pinhole_point_projection #(
  parameter int COORD_FRAC_BITS = ppp_pkg::COORD_FRAC_BITS_DEF,
  parameter int COEF_FRAC_BITS  = ppp_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  output logic               done,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               depth_invalid
);

  localparam int CTR_UP     = (COORD_FRAC_BITS >= ppp_pkg::FOCAL_FRAC) ?
                              COORD_FRAC_BITS - ppp_pkg::FOCAL_FRAC : 0;
  localparam int CTR_DN     = (COORD_FRAC_BITS >= ppp_pkg::FOCAL_FRAC) ?
                              0 : ppp_pkg::FOCAL_FRAC - COORD_FRAC_BITS;
  localparam int PROJ_SHIFT = 2 * ppp_pkg::FOCAL_FRAC - COORD_FRAC_BITS;
  localparam logic signed [31:0] RAY_Z = 32'(64'd1 << COORD_FRAC_BITS);
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam int NW = ppp_pkg::DIV_NUM_W;
  localparam int DW = ppp_pkg::DIV_DEN_W;
  localparam int MW = ppp_pkg::MAG_W;

  function automatic logic [ppp_pkg::CTR_W-1:0] to_coord(input logic [23:0] c);
    return ppp_pkg::CTR_W'((64'(c) << CTR_UP) >> CTR_DN);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'(S32_MAX)) return S32_MAX;
    if (x < 64'(S32_MIN)) return S32_MIN;
    return x[31:0];
  endfunction

  // configuration registers
  logic [47:0] rot_row [3];
  logic [63:0] trans_xy;
  logic [31:0] trans_z;
  logic [47:0] focal;
  logic [47:0] ppoint;
  logic [25:0] img_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) rot_row[k] <= 48'(ppp_pkg::ROT_ONE) << (16 * k);
      trans_xy <= '0;
      trans_z  <= '0;
      focal    <= '0;
      ppoint   <= '0;
      img_ctl  <= '0;
    end else if (cfg_write) begin
      unique case (ppp_pkg::reg_idx_t'(cfg_index))
        ppp_pkg::REG_ROT_ROW0:  rot_row[0] <= cfg_data[47:0];
        ppp_pkg::REG_ROT_ROW1:  rot_row[1] <= cfg_data[47:0];
        ppp_pkg::REG_ROT_ROW2:  rot_row[2] <= cfg_data[47:0];
        ppp_pkg::REG_TRANS_XY:  trans_xy   <= cfg_data;
        ppp_pkg::REG_TRANS_Z:   trans_z    <= cfg_data[31:0];
        ppp_pkg::REG_FOCAL:     focal      <= cfg_data[47:0];
        ppp_pkg::REG_PRINCIPAL: ppoint     <= cfg_data[47:0];
        ppp_pkg::REG_IMAGE_CTL: img_ctl    <= cfg_data[25:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  logic signed [15:0] coef [3][3];
  logic signed [32:0] tn [3];
  logic [1:0][23:0]   fl, ctr_raw;
  logic [1:0][11:0]   img_size;
  logic               rot_en, tr_en;

  for (genvar r = 0; r < 3; r++) begin : g_coef_r
    for (genvar c = 0; c < 3; c++) begin : g_coef_c
      assign coef[r][c] = rot_row[r][16*c +: 16];
    end
  end

  assign tn[0] = -$signed({trans_xy[31], trans_xy[31:0]});
  assign tn[1] = -$signed({trans_xy[63], trans_xy[63:32]});
  assign tn[2] = -$signed({trans_z[31], trans_z});
  assign fl[0] = focal[23:0];
  assign fl[1] = focal[47:24];
  assign ctr_raw[0] = ppoint[23:0];
  assign ctr_raw[1] = ppoint[47:24];
  assign img_size[0] = img_ctl[11:0];
  assign img_size[1] = img_ctl[23:12];
  assign rot_en = img_ctl[24];
  assign tr_en  = img_ctl[25];

  // stage a: products of the transposed rotation
  logic signed [31:0] p_in [3];
  logic               a_valid;
  ppp_pkg::req_t      a_req;
  logic signed [31:0] a_p [3];
  logic signed [48:0] a_pp [3][3];
  logic signed [48:0] a_tp [3][3];

  assign p_in[0] = coord_x;
  assign p_in[1] = coord_y;
  assign p_in[2] = coord_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_req <= ppp_pkg::req_t'(req_type);
    for (int i = 0; i < 3; i++) begin
      a_p[i] <= p_in[i];
      for (int j = 0; j < 3; j++) begin
        a_pp[i][j] <= 49'(coef[j][i]) * 49'(p_in[j]);
        a_tp[i][j] <= 49'(coef[j][i]) * 49'(tn[j]);
      end
    end
  end

  // stage b: camera frame and pixel offsets
  logic signed [50:0] sum_p [3], sum_t [3], cam_rot [3], cam_tr [3];
  logic signed [51:0] cam_sum [3];
  logic signed [38:0] cam_sat [3];
  logic               b_valid;
  ppp_pkg::req_t      b_req;
  logic signed [38:0] b_c [3];
  logic signed [37:0] b_diff [2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_p[i] = 51'(a_pp[i][0]) + 51'(a_pp[i][1]) + 51'(a_pp[i][2]);
      sum_t[i] = 51'(a_tp[i][0]) + 51'(a_tp[i][1]) + 51'(a_tp[i][2]);
      cam_rot[i] = rot_en ? (sum_p[i] >>> COEF_FRAC_BITS) : 51'(a_p[i]);
      if (!tr_en) begin
        cam_tr[i] = '0;
      end else if (rot_en) begin
        cam_tr[i] = sum_t[i] >>> COEF_FRAC_BITS;
      end else begin
        cam_tr[i] = 51'(tn[i]);
      end
      cam_sum[i] = 52'(cam_rot[i]) + 52'(cam_tr[i]);
      if (cam_sum[i] > 52'(ppp_pkg::CAM_LIMIT)) begin
        cam_sat[i] = ppp_pkg::CAM_LIMIT;
      end else if (cam_sum[i] < -52'(ppp_pkg::CAM_LIMIT)) begin
        cam_sat[i] = -ppp_pkg::CAM_LIMIT;
      end else begin
        cam_sat[i] = cam_sum[i][38:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_req <= a_req;
    for (int i = 0; i < 3; i++) b_c[i] <= cam_sat[i];
    for (int l = 0; l < 2; l++) begin
      b_diff[l] <= 38'(a_p[l]) - $signed({2'b00, to_coord(ctr_raw[l])});
    end
  end

  // stage c: numerators and denominators for the divider
  logic signed [63:0] prod_f [2];
  logic [63:0]        mag_f [2];
  logic [37:0]        mag_b [2];
  logic [MW-1:0]      mag [2];
  logic [1:0]         neg_c, nz_c;
  ppp_pkg::ppp_ctl_t  c_ctl;
  logic [1:0][NW-1:0] c_num;
  logic [1:0][DW-1:0] c_den;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod_f[l] = 64'($signed({1'b0, fl[l]})) * 64'(b_c[l]);
      mag_f[l]  = prod_f[l][63] ? 64'(-prod_f[l]) : 64'(prod_f[l]);
      mag_b[l]  = b_diff[l][37] ? 38'(-b_diff[l]) : 38'(b_diff[l]);
      if (b_req == ppp_pkg::REQ_FWD) begin
        mag[l]   = mag_f[l][MW-1:0];
        neg_c[l] = prod_f[l][63];
      end else begin
        mag[l]   = MW'(mag_b[l]);
        neg_c[l] = b_diff[l][37];
      end
      nz_c[l] = (mag[l] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl <= '0;
    end else begin
      c_ctl.valid <= b_valid;
      c_ctl.req   <= b_req;
      c_ctl.inv   <= (b_req == ppp_pkg::REQ_FWD) && (b_c[2] <= 39'sd0);
      c_ctl.neg   <= neg_c;
      c_ctl.nz    <= nz_c;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      c_num[l] <= {mag[l], {ppp_pkg::FOCAL_FRAC{1'b0}}};
      c_den[l] <= (b_req == ppp_pkg::REQ_FWD) ? b_c[2][DW-1:0] : DW'(fl[l]);
    end
  end

  ppp_pkg::ppp_ctl_t  q_ctl;
  logic [1:0][NW-1:0] quo;

  ppp_div #(
    .NUM_W (NW),
    .DEN_W (DW),
    .STEPS (ppp_pkg::DIV_STEPS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (c_ctl),
    .in_num  (c_num),
    .in_den  (c_den),
    .out_ctl (q_ctl),
    .out_quo (quo)
  );

  // stage d: pixel clamp or ray component
  logic [MW-1:0]      q_int [2];
  logic [31:0]        q_sat [2];
  logic [43:0]        val [2];
  logic signed [44:0] sval [2];
  logic signed [47:0] pix [2], lim [2];
  logic signed [31:0] res_c [2];
  ppp_pkg::ppp_ctl_t  d_ctl;
  logic signed [31:0] d_res [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q_int[l] = quo[l][NW-1:ppp_pkg::FOCAL_FRAC];
      q_sat[l] = (q_int[l] > MW'(33'h0_8000_0000)) ? 32'h8000_0000 : q_int[l][31:0];
      val[l]   = {q_sat[l], quo[l][ppp_pkg::FOCAL_FRAC-1:0]} >> PROJ_SHIFT;
      sval[l]  = q_ctl.neg[l] ? -$signed({1'b0, val[l]}) : $signed({1'b0, val[l]});
      pix[l]   = 48'(sval[l]) + $signed({12'b0, to_coord(ctr_raw[l])});
      lim[l]   = (48'($signed({1'b0, img_size[l]})) - 48'sd1) <<< COORD_FRAC_BITS;
      if (pix[l] < 48'sd0) pix[l] = '0;
      if (pix[l] > lim[l]) pix[l] = lim[l];
      if (q_ctl.req == ppp_pkg::REQ_FWD) begin
        res_c[l] = q_ctl.inv ? '0 : sat32(64'(pix[l]));
      end else if (fl[l] == '0) begin
        if (!q_ctl.nz[l]) begin
          res_c[l] = '0;
        end else begin
          res_c[l] = q_ctl.neg[l] ? S32_MIN : S32_MAX;
        end
      end else if (q_ctl.neg[l]) begin
        res_c[l] = (quo[l] > NW'(33'h0_8000_0000)) ? S32_MIN : 32'(-quo[l][31:0]);
      end else begin
        res_c[l] = (quo[l] > NW'(33'h0_7FFF_FFFF)) ? S32_MAX : quo[l][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl <= '0;
    end else begin
      d_ctl <= q_ctl;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) d_res[l] <= res_c[l];
  end

  // stage e: products of the ray rotation
  logic signed [31:0] ray [3];
  ppp_pkg::ppp_ctl_t  e_ctl;
  logic signed [31:0] e_res [2];
  logic signed [47:0] e_pp [3][3];

  assign ray[0] = d_res[0];
  assign ray[1] = d_res[1];
  assign ray[2] = RAY_Z;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_ctl <= '0;
    end else begin
      e_ctl <= d_ctl;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) e_res[l] <= d_res[l];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) e_pp[i][j] <= 48'(coef[i][j]) * 48'(ray[j]);
    end
  end

  // stage f: ray sums and output register
  logic signed [49:0] ray_sum [3];
  logic signed [31:0] ray_rot [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ray_sum[i] = 50'(e_pp[i][0]) + 50'(e_pp[i][1]) + 50'(e_pp[i][2]);
      ray_rot[i] = sat32(64'(ray_sum[i] >>> COEF_FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= e_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    unique case (e_ctl.req)
      ppp_pkg::REQ_FWD: begin
        out_x         <= e_res[0];
        out_y         <= e_res[1];
        out_z         <= '0;
        depth_invalid <= e_ctl.inv;
      end
      ppp_pkg::REQ_BWD: begin
        out_x         <= rot_en ? ray_rot[0] : e_res[0];
        out_y         <= rot_en ? ray_rot[1] : e_res[1];
        out_z         <= rot_en ? ray_rot[2] : RAY_Z;
        depth_invalid <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/ppp_check.sv
// port checker for the pinhole point projection block, with its bind
// depends on ppp_pkg and pinhole_point_projection_macros.svh
`default_nettype none

`include "pinhole_point_projection_macros.svh"

module ppp_check (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               depth_invalid,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z
);

  localparam int LAT = ppp_pkg::PIPE_LAT;

  `PPP_ASSERT_ALWAYS(a_reset_quiet, rst |=> !done, "result strobe right after reset")
  `PPP_ASSERT_ALWAYS(a_ready_after_reset, !rst |=> !busy, "busy outside reset")
  `PPP_ASSERT(a_request_done, (start && !busy) |-> ##LAT done, "request gave no result")
  `PPP_ASSERT(a_done_from_request, done |-> $past(start && !busy, LAT), "result without request")
  `PPP_ASSERT(a_invalid_zero, (done && depth_invalid) |-> (out_x == 0 && out_y == 0 && out_z == 0), "invalid depth with nonzero result")

endmodule

bind pinhole_point_projection ppp_check u_ppp_check (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .depth_invalid (depth_invalid),
  .out_x         (out_x),
  .out_y         (out_y),
  .out_z         (out_z)
);

`default_nettype wire

### tb/tb_top.sv
// testbench for the pinhole point projection block, forward and backward requests
// predicts each result in fixed point and checks the result stream; needs ppp_pkg
`timescale 1ns / 100ps

module tb_top;
  import ppp_pkg::*;

  typedef struct {
    req_t               req;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_req_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               inv;
  } point_res_t;

  localparam int COORD_FB = 16;
  localparam int COEF_FB  = 14;
  localparam longint CAM_MAX = 64'sd274877906943;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               start = 1'b0;
  logic               busy;
  logic               req_type = 1'b0;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_y = '0;
  logic signed [31:0] coord_z = '0;
  logic               done;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               depth_invalid;

  logic [63:0] cam_regs [8];
  point_res_t  pending_results [$];
  int          idle_pct = 0;
  int          errors = 0;

  pinhole_point_projection u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .start(start), .busy(busy), .req_type(req_type),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .done(done),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .depth_invalid(depth_invalid)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint coef(int row, int col);
    logic [47:0] r;
    r = cam_regs[int'(REG_ROT_ROW0) + row][47:0];
    return longint'($signed(r[col*16 +: 16]));
  endfunction

  function automatic void rotate_transposed(input longint a [3], output longint o [3]);
    longint s;
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int j = 0; j < 3; j++) s += coef(j, i) * a[j];
      o[i] = s >>> COEF_FB;
    end
  endfunction

  function automatic longint project_axis(longint f, longint v, longint d);
    longint n;
    logic neg;
    longint unsigned mag, q, r, val;
    n = f * v;
    neg = n < 0;
    mag = neg ? -n : n;
    q = mag / d;
    r = mag % d;
    if (q > 64'd2147483648) q = 64'd2147483648;
    val = ((q << 12) | ((r << 12) / d)) >> 8;
    return neg ? -longint'(val) : longint'(val);
  endfunction

  function automatic longint clamp_pixel(longint v, longint size);
    longint hi;
    hi = (size - 1) * (longint'(1) << COORD_FB);
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic longint ray_axis(longint p, longint c, longint f);
    longint diff;
    diff = p - c * 16;
    if (f == 0) return diff == 0 ? 0 : (diff > 0 ? I32_MAX : I32_MIN);
    return sat((diff * 4096) / f, I32_MIN, I32_MAX);
  endfunction

  function automatic point_res_t predict_projection(point_req_t rq);
    point_res_t res;
    logic rot_en, tr_en;
    longint fx, fy, cx, cy, w, h;
    longint p [3], c [3], t [3], tn [3], v [3], r [3];
    longint s;
    rot_en = cam_regs[REG_IMAGE_CTL][24];
    tr_en = cam_regs[REG_IMAGE_CTL][25];
    fx = cam_regs[REG_FOCAL][23:0];
    fy = cam_regs[REG_FOCAL][47:24];
    cx = cam_regs[REG_PRINCIPAL][23:0];
    cy = cam_regs[REG_PRINCIPAL][47:24];
    w = cam_regs[REG_IMAGE_CTL][11:0];
    h = cam_regs[REG_IMAGE_CTL][23:12];
    p[0] = rq.x;
    p[1] = rq.y;
    p[2] = rq.z;
    r = '{0, 0, 0};
    res.inv = 1'b0;
    if (rq.req == REQ_FWD) begin
      if (rot_en) rotate_transposed(p, c);
      else c = p;
      if (tr_en) begin
        tn[0] = -longint'($signed(cam_regs[REG_TRANS_XY][31:0]));
        tn[1] = -longint'($signed(cam_regs[REG_TRANS_XY][63:32]));
        tn[2] = -longint'($signed(cam_regs[REG_TRANS_Z][31:0]));
        if (rot_en) rotate_transposed(tn, t);
        else t = tn;
        for (int i = 0; i < 3; i++) c[i] += t[i];
      end
      for (int i = 0; i < 3; i++) c[i] = sat(c[i], -CAM_MAX, CAM_MAX);
      if (c[2] <= 0) begin
        res.inv = 1'b1;
      end else begin
        r[0] = sat(clamp_pixel(project_axis(fx, c[0], c[2]) + cx * 16, w), I32_MIN, I32_MAX);
        r[1] = sat(clamp_pixel(project_axis(fy, c[1], c[2]) + cy * 16, h), I32_MIN, I32_MAX);
      end
    end else begin
      v[0] = ray_axis(p[0], cx, fx);
      v[1] = ray_axis(p[1], cy, fy);
      v[2] = longint'(1) << COORD_FB;
      for (int i = 0; i < 3; i++) begin
        if (rot_en) begin
          s = 0;
          for (int j = 0; j < 3; j++) s += coef(i, j) * v[j];
          r[i] = sat(s >>> COEF_FB, I32_MIN, I32_MAX);
        end else begin
          r[i] = sat(v[i], I32_MIN, I32_MAX);
        end
      end
    end
    res.x = r[0][31:0];
    res.y = r[1][31:0];
    res.z = r[2][31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    point_res_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h inv=%b", $time,
                 out_x, out_y, out_z, depth_invalid);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_x !== exp_res.x) begin
          $display("%0t: out_x expected %h actual %h", $time, exp_res.x, out_x);
          errors++;
        end
        if (out_y !== exp_res.y) begin
          $display("%0t: out_y expected %h actual %h", $time, exp_res.y, out_y);
          errors++;
        end
        if (out_z !== exp_res.z) begin
          $display("%0t: out_z expected %h actual %h", $time, exp_res.z, out_z);
          errors++;
        end
        if (depth_invalid !== exp_res.inv) begin
          $display("%0t: depth_invalid expected %b actual %b", $time, exp_res.inv,
                   depth_invalid);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    logic [63:0] m;
    case (idx)
      REG_TRANS_XY: m = '1;
      REG_TRANS_Z: m = 64'hFFFF_FFFF;
      REG_IMAGE_CTL: m = 64'h3FF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF;
    endcase
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    cam_regs[idx] = val & m;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_point(point_req_t rq);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    req_type <= rq.req;
    coord_x <= rq.x;
    coord_y <= rq.y;
    coord_z <= rq.z;
    while (busy) @(negedge clk);
    pending_results.push_back(predict_projection(rq));
    @(posedge clk);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    start <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return $signed(($urandom & 32'h001F_FFFF) - 32'h0010_0000);
      default: return $signed(($urandom & 32'h07FF_FFFF) - 32'h0400_0000);
    endcase
  endfunction

  function automatic logic [47:0] rand_rotation_row(int row);
    logic [47:0] r;
    int k;
    case ($urandom_range(3))
      0: return 48'({$urandom, $urandom});
      1: begin
        r = '0;
        k = $urandom_range(2);
        r[k*16 +: 16] = $urandom_range(1) ? ROT_ONE : -ROT_ONE;
        return r;
      end
      default: begin
        r = '0;
        for (int c = 0; c < 3; c++)
          r[c*16 +: 16] = (c == row) ? 16'(16384 - $urandom_range(2000)) :
                                       16'($signed($urandom_range(2000)) - 1000);
        return r;
      end
    endcase
  endfunction

  task automatic load_random_config();
    for (int i = 0; i < 3; i++)
      write_reg(reg_idx_t'(i), 64'(rand_rotation_row(i)));
    write_reg(REG_TRANS_XY, $urandom_range(1) ? {$urandom, $urandom} :
              {32'($signed(rand_coord()) >>> 6), 32'($signed(rand_coord()) >>> 6)});
    write_reg(REG_TRANS_Z, {$urandom, $urandom} & 64'h0000_0000_00FF_FFFF);
    write_reg(REG_FOCAL, {$urandom_range(3) == 0 ? 24'hFFFFFF : 24'($urandom),
                          $urandom_range(7) == 0 ? 24'h0 : 24'($urandom)});
    write_reg(REG_PRINCIPAL, {$urandom, $urandom});
    write_reg(REG_IMAGE_CTL, {$urandom, $urandom});
  endtask

  task automatic load_camera(logic rot_en, logic tr_en);
    for (int i = 0; i < 3; i++) write_reg(reg_idx_t'(i), 64'(ROT_ONE) << (16 * i));
    write_reg(REG_TRANS_XY, {32'h0001_0000, 32'hFFFE_0000});
    write_reg(REG_TRANS_Z, 64'hFFFF_0000);
    write_reg(REG_FOCAL, {24'd2000 << 12, 24'd1500 << 12});
    write_reg(REG_PRINCIPAL, {24'd240 << 12, 24'd320 << 12});
    write_reg(REG_IMAGE_CTL, {tr_en, rot_en, 12'd480, 12'd640});
  endtask

  task automatic test_reset_defaults();
    send_point('{REQ_FWD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000});
    send_point('{REQ_FWD, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000});
    send_point('{REQ_BWD, 32'h0000_0000, 32'h0005_0000, 32'h0});
    send_point('{REQ_BWD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0});
    stop_sending();
    wait_drained();
  endtask

  task automatic test_directed_points();
    load_camera(1'b1, 1'b1);
    send_point('{REQ_FWD, 32'h0, 32'h0, 32'h0005_0000});
    send_point('{REQ_FWD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001});
    send_point('{REQ_FWD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_point('{REQ_FWD, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000});
    send_point('{REQ_FWD, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000});
    send_point('{REQ_FWD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_point('{REQ_BWD, 32'h0140_0000, 32'h00F0_0000, 32'h1234_5678});
    send_point('{REQ_BWD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0});
    send_point('{REQ_BWD, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
    stop_sending();
    wait_drained();
    write_reg(REG_FOCAL, 64'h0);
    write_reg(REG_IMAGE_CTL, 64'h0);
    send_point('{REQ_BWD, 32'h0140_0000, 32'h00F0_0000, 32'h0});
    send_point('{REQ_BWD, 32'h0141_0000, 32'h00EF_0000, 32'h0});
    send_point('{REQ_FWD, 32'h0010_0000, 32'h0010_0000, 32'h0001_0000});
    stop_sending();
    wait_drained();
    write_reg(REG_FOCAL, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_PRINCIPAL, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_IMAGE_CTL, 64'h3FF_FFFF);
    for (int i = 0; i < 3; i++) write_reg(reg_idx_t'(i), 64'hFFFF_FFFF_FFFF);
    send_point('{REQ_FWD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
    send_point('{REQ_FWD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_point('{REQ_BWD, 32'h7FFF_FFFF, 32'h0, 32'h0});
    send_point('{REQ_BWD, 32'h0, 32'h8000_0000, 32'h0});
    stop_sending();
    wait_drained();
  endtask

  task automatic run_random_points(int count);
    point_req_t rq;
    for (int n = 0; n < count; n++) begin
      rq.req = $urandom_range(2) == 0 ? REQ_BWD : REQ_FWD;
      rq.x = rand_coord();
      rq.y = rand_coord();
      rq.z = ($urandom_range(4) == 0) ? rand_coord() : 32'($urandom_range(32'h0FFF_FFFF, 1));
      send_point(rq);
      // drain once mid-run so the pipeline empties with requests still to come
      if (n == count / 2) begin
        stop_sending();
        while (pending_results.size() != 0) @(negedge clk);
      end
    end
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random_streams();
    idle_pct = 32;
    load_camera(1'b1, 1'b1);
    run_random_points(130);
    load_random_config();
    run_random_points(130);
    idle_pct = 60;
    load_camera(1'b0, 1'b1);
    run_random_points(130);
    load_random_config();
    run_random_points(130);
    idle_pct = 0;
    load_camera(1'b1, 1'b0);
    run_random_points(130);
    load_random_config();
    run_random_points(130);
  endtask

  initial begin
    cam_regs[REG_ROT_ROW0] = 64'(ROT_ONE);
    cam_regs[REG_ROT_ROW1] = 64'(ROT_ONE) << 16;
    cam_regs[REG_ROT_ROW2] = 64'(ROT_ONE) << 32;
    for (int i = 3; i < 8; i++) cam_regs[i] = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_points();
    test_random_streams();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/ppp_pkg.sv
rtl/core/ppp_div.sv
rtl/core/pinhole_point_projection.sv
rtl/core/ppp_check.sv
tb/tb_top.sv
